@@ rtl/power_presence_uptime_monitor_defines.svh @@
// ----------------------------------------------------------------------------
// Power presence uptime monitor: assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef POWER_PRESENCE_UPTIME_MONITOR_DEFINES_SVH
`define POWER_PRESENCE_UPTIME_MONITOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PPUM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppum check failed");

// next-cycle implication, disabled in reset
`define PPUM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppum check failed");

`endif

@@ rtl/ppum_pkg.sv @@
// ----------------------------------------------------------------------------
// ppum_pkg
// Types, constants and helpers shared by the power presence uptime monitor.
// ----------------------------------------------------------------------------
package ppum_pkg;

  localparam int ACC_WIDTH   = 32;
  localparam int DEB_WIDTH   = 16;
  localparam int CONF_WIDTH  = 24;
  localparam int REP_WIDTH   = 32;
  localparam int CFG_WIDTH   = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CMP_WIDTH   = (ACC_WIDTH > REP_WIDTH) ? ACC_WIDTH : REP_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_LOW  = CFG_IDX_W'(2);

  localparam logic [DEB_WIDTH-1:0]  DEBOUNCE_RESET = DEB_WIDTH'(50);
  localparam logic [CONF_WIDTH-1:0] CONFIRM_RESET  = CONF_WIDTH'(10000);

  localparam logic [DEB_WIDTH-1:0]  RAW_CNT_MAX  = '1;
  localparam logic [CONF_WIDTH-1:0] CAND_CNT_MAX = '1;
  localparam logic [ACC_WIDTH-1:0]  ACC_MAX      = '1;
  localparam logic [REP_WIDTH-1:0]  REPORT_MAX   = '1;

  typedef struct packed {
    logic was_on;
    logic power_on;
    logic went_online;
    logic went_offline;
  } filt_status_t;

  typedef struct packed {
    logic                 day_valid;
    logic [REP_WIDTH-1:0] day_total;
    logic                 month_valid;
    logic [REP_WIDTH-1:0] month_total;
  } ontime_report_t;

  function automatic logic [REP_WIDTH-1:0] report_of(input logic [ACC_WIDTH-1:0] v);
    logic [CMP_WIDTH-1:0] ve;
    ve = CMP_WIDTH'(v);
    if (ve > CMP_WIDTH'(REPORT_MAX)) begin
      return REPORT_MAX;
    end
    return ve[REP_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/ppum_filter.sv @@
// ----------------------------------------------------------------------------
// ppum_filter
// Debounce and confirm filter: raw level to confirmed power state and edges.
// ----------------------------------------------------------------------------
module ppum_filter import ppum_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  raw_level,
  input  logic [DEB_WIDTH-1:0]  debounce_ticks,
  input  logic [CONF_WIDTH-1:0] confirm_ticks,
  output filt_status_t          status
);

  logic                  last_raw;
  logic [DEB_WIDTH-1:0]  raw_cnt;
  logic                  cand;
  logic [CONF_WIDTH-1:0] cand_cnt;
  logic                  conf;

  logic [DEB_WIDTH-1:0]  raw_cnt_next;
  logic                  cand_next;
  logic [CONF_WIDTH-1:0] cand_cnt_next;
  logic                  conf_next;
  logic                  gate;
  logic                  flip;

  always_comb begin
    if (raw_level != last_raw) begin
      raw_cnt_next = '0;
    end else if (raw_cnt != RAW_CNT_MAX) begin
      raw_cnt_next = raw_cnt + DEB_WIDTH'(1);
    end else begin
      raw_cnt_next = raw_cnt;
    end

    gate = raw_cnt_next > debounce_ticks;

    cand_next = gate ? raw_level : cand;
    if (gate && (raw_level != cand)) begin
      cand_cnt_next = '0;
    end else if (cand_cnt != CAND_CNT_MAX) begin
      cand_cnt_next = cand_cnt + CONF_WIDTH'(1);
    end else begin
      cand_cnt_next = cand_cnt;
    end

    flip      = gate && (cand_cnt_next >= confirm_ticks) && (cand_next != conf);
    conf_next = flip ? cand_next : conf;

    status.was_on       = conf;
    status.power_on     = conf_next;
    status.went_online  = flip && cand_next;
    status.went_offline = flip && !cand_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b0;
      raw_cnt  <= '0;
      cand     <= 1'b0;
      cand_cnt <= '0;
      conf     <= 1'b0;
    end else if (advance) begin
      last_raw <= raw_level;
      raw_cnt  <= raw_cnt_next;
      cand     <= cand_next;
      cand_cnt <= cand_cnt_next;
      conf     <= conf_next;
    end
  end

endmodule

@@ rtl/ppum_ontime.sv @@
// ----------------------------------------------------------------------------
// ppum_ontime
// Day and month on-time accumulators with saturation and rollover reports.
// ----------------------------------------------------------------------------
module ppum_ontime import ppum_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           was_on,
  input  logic           day_rollover,
  input  logic           month_rollover,
  output ontime_report_t report
);

  logic [ACC_WIDTH-1:0] day_acc;
  logic [ACC_WIDTH-1:0] month_acc;
  logic [ACC_WIDTH-1:0] day_inc;
  logic [ACC_WIDTH-1:0] month_inc;
  logic [ACC_WIDTH-1:0] day_acc_next;
  logic [ACC_WIDTH-1:0] month_acc_next;

  always_comb begin
    day_inc   = (was_on && (day_acc != ACC_MAX)) ? day_acc + ACC_WIDTH'(1) : day_acc;
    month_inc = (was_on && (month_acc != ACC_MAX)) ? month_acc + ACC_WIDTH'(1) : month_acc;

    day_acc_next   = day_rollover ? '0 : day_inc;
    month_acc_next = month_rollover ? '0 : month_inc;

    report.day_valid   = day_rollover;
    report.day_total   = day_rollover ? report_of(day_inc) : '0;
    report.month_valid = month_rollover;
    report.month_total = month_rollover ? report_of(month_inc) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_acc   <= '0;
      month_acc <= '0;
    end else if (advance) begin
      day_acc   <= day_acc_next;
      month_acc <= month_acc_next;
    end
  end

endmodule

@@ rtl/power_presence_uptime_monitor.sv @@
// ----------------------------------------------------------------------------
// power_presence_uptime_monitor: debounced power state and on-time counters
// An input beat passes the input reg and then the result reg to reach the result beat.
// Throughput one beat per cycle while out_stall is low; a stalled result blocks the next tick.
// Sync reset clears valid flags and filter and on-time state; registers return to 50 / 10000 / 0.
// ----------------------------------------------------------------------------
module power_presence_uptime_monitor import ppum_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  raw_level,
  input  logic                  day_rollover,
  input  logic                  month_rollover,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  mirror_drive,
  output logic                  power_on,
  output logic                  went_online,
  output logic                  went_offline,
  output logic                  day_report_valid,
  output logic [REP_WIDTH-1:0]  day_on_total,
  output logic                  month_report_valid,
  output logic [REP_WIDTH-1:0]  month_on_total
);

  logic [DEB_WIDTH-1:0]  debounce_ticks;
  logic [CONF_WIDTH-1:0] confirm_ticks;
  logic                  mirror_invert;

  logic s1_valid;
  logic s1_raw;
  logic s1_day;
  logic s1_month;

  logic out_ready;
  logic advance;
  logic in_take;

  filt_status_t   status;
  ontime_report_t report;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      confirm_ticks  <= CONFIRM_RESET;
      mirror_invert  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_ticks <= cfg_data[DEB_WIDTH-1:0];
        REG_CONFIRM:    confirm_ticks  <= cfg_data[CONF_WIDTH-1:0];
        REG_MIRROR_LOW: mirror_invert  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (out_ready || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw   <= raw_level;
      s1_day   <= day_rollover;
      s1_month <= month_rollover;
    end
  end

  ppum_filter u_filter (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .raw_level      (s1_raw),
    .debounce_ticks (debounce_ticks),
    .confirm_ticks  (confirm_ticks),
    .status         (status)
  );

  ppum_ontime u_ontime (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .was_on         (status.was_on),
    .day_rollover   (s1_day),
    .month_rollover (s1_month),
    .report         (report)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mirror_drive       <= status.power_on ^ mirror_invert;
      power_on           <= status.power_on;
      went_online        <= status.went_online;
      went_offline       <= status.went_offline;
      day_report_valid   <= report.day_valid;
      day_on_total       <= report.day_total;
      month_report_valid <= report.month_valid;
      month_on_total     <= report.month_total;
    end
  end

endmodule

@@ rtl/ppum_checker.sv @@
// ----------------------------------------------------------------------------
// ppum_checker
// Port-level checks for the power presence uptime monitor, bound to the top.
// ----------------------------------------------------------------------------
`include "power_presence_uptime_monitor_defines.svh"

module ppum_checker import ppum_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 power_on,
  input logic                 went_online,
  input logic                 went_offline,
  input logic                 day_report_valid,
  input logic [REP_WIDTH-1:0] day_on_total,
  input logic                 month_report_valid,
  input logic [REP_WIDTH-1:0] month_on_total
);

  `PPUM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `PPUM_ASSERT_NOW(a_online_state, out_valid && went_online, power_on && !went_offline)
  `PPUM_ASSERT_NOW(a_offline_state, out_valid && went_offline, !power_on)
  `PPUM_ASSERT_NOW(a_day_idle_zero, out_valid && !day_report_valid, day_on_total == '0)
  `PPUM_ASSERT_NOW(a_month_idle_zero, out_valid && !month_report_valid, month_on_total == '0)

endmodule

bind power_presence_uptime_monitor ppum_checker u_ppum_checker (.*);
